// ===== rtl/command_line_argument_splitter_macros.svh =====
// Assertion macros for the command line argument splitter.
// Included by every RTL file that carries concurrent assertions; expects clk_i and rst_ni.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_MACROS_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checked outside reset
`define CLAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("clas assertion failed");
// implication from antecedent to consequent in the same cycle
`define CLAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clas assertion failed");
// implication into the following cycle
`define CLAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clas assertion failed");
`else
`define CLAS_ASSERT(lbl, prop)
`define CLAS_ASSERT_IMP(lbl, ante, cons)
`define CLAS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/clas_pkg.sv =====
// Shared types and constants of the command line argument splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package clas_pkg;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChNul       = 8'h00;

  // backslash run limit; the run counter is 8 bits, so it stops at 255 at most
  localparam int unsigned MaxSlashRun = 255;
  localparam int unsigned RunCapInt   = (MaxSlashRun < 255) ? MaxSlashRun : 255;
  localparam logic [7:0]  RunCap      = 8'(RunCapInt);

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_NUL   = 3'd1,
    CLS_SLASH = 3'd2,
    CLS_QUOTE = 3'd3,
    CLS_SPACE = 3'd4
  } char_class_e;

  typedef struct packed {
    logic [7:0]  ch;
    char_class_e cls;
  } item_t;

  typedef struct packed {
    logic [7:0]  slash_count;
    logic        char_valid;
    logic [7:0]  char_value;
    logic        arg_start;
    logic        arg_end;
    logic        line_end;
    logic [7:0]  arg_count;
    logic [15:0] char_count;
    logic        run_overflow;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/clas_front.sv =====
// Front stage: accepts input bytes, classifies them and registers the item.
// Depends on clas_pkg.
`default_nettype none

module clas_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          ch_i,
  output logic                item_valid_o,
  input  wire                 item_ready_i,
  output clas_pkg::item_t     item_o
);
  import clas_pkg::*;

  logic        valid_q;
  item_t       item_q;
  char_class_e cls;

  always_comb begin
    unique case (ch_i)
      ChNul:                     cls = CLS_NUL;
      ChBackslash:               cls = CLS_SLASH;
      ChQuote:                   cls = CLS_QUOTE;
      ChSpace, ChTab, ChCr, ChLf: cls = CLS_SPACE;
      default:                   cls = CLS_OTHER;
    endcase
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{ch: ch_i, cls: cls};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clas_queue.sv =====
// Two-entry queue of classified items between the front and back stages.
// Depends on clas_pkg and the assertion macros.
`default_nettype none
`include "command_line_argument_splitter_macros.svh"

module clas_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  clas_pkg::item_t     push_item_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output clas_pkg::item_t     pop_item_o
);
  import clas_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `CLAS_ASSERT(a_cnt_bound, cnt_q != 2'd3)

endmodule

`default_nettype wire

// ===== rtl/clas_back.sv =====
// Back stage: carries out the splitting rules on each item and holds the result register.
// Depends on clas_pkg and the assertion macros.
`default_nettype none
`include "command_line_argument_splitter_macros.svh"

module clas_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  output logic                item_ready_o,
  input  clas_pkg::item_t     item_i,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output clas_pkg::result_t   res_o
);
  import clas_pkg::*;

  // splitter state
  logic        in_arg_q, in_arg_d;
  logic        in_quotes_q, in_quotes_d;
  logic        close_pend_q, close_pend_d;
  logic [7:0]  run_q, run_d;
  logic        ovf_q, ovf_d;
  logic [7:0]  args_q, args_d;
  logic [15:0] bytes_q, bytes_d;

  logic        res_valid_q;
  result_t     res_q;

  logic        pop;
  logic        emit;
  logic        done;
  logic        inq;
  logic [7:0]  run;
  logic [8:0]  add_n;
  logic [16:0] sum;
  result_t     res;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    in_arg_d     = in_arg_q;
    in_quotes_d  = in_quotes_q;
    close_pend_d = close_pend_q;
    run_d        = run_q;
    ovf_d        = ovf_q;
    args_d       = args_q;
    emit         = 1'b0;
    done         = 1'b0;
    inq          = in_quotes_q;
    run          = run_q;
    add_n        = 9'd0;
    res          = '0;

    // a quote after a quote inside quotes: literal quote, quoting ends
    if (close_pend_q) begin
      close_pend_d = 1'b0;
      in_quotes_d  = 1'b0;
      inq          = 1'b0;
      if (item_i.cls == CLS_QUOTE) begin
        res.char_valid = 1'b1;
        res.char_value = ChQuote;
        add_n          = 9'd1;
        emit           = 1'b1;
        done           = 1'b1;
      end
    end

    if (!done && item_i.cls == CLS_NUL) begin
      res.line_end = 1'b1;
      if (in_arg_q) begin
        res.slash_count = run_q;
        res.arg_end     = 1'b1;
        add_n           = {1'b0, run_q} + 9'd1;
      end
      emit = 1'b1;
      done = 1'b1;
    end

    if (!done && !in_arg_q) begin
      if (item_i.cls == CLS_SPACE) begin
        done = 1'b1;
      end else begin
        in_arg_d      = 1'b1;
        args_d        = (args_q != 8'hFF) ? args_q + 8'd1 : args_q;
        res.arg_start = 1'b1;
        emit          = 1'b1;
        run           = 8'd0;
        run_d         = 8'd0;
      end
    end

    if (!done) begin
      unique case (item_i.cls)
        CLS_SLASH: begin
          if (run < RunCap) run_d = run + 8'd1;
          else              ovf_d = 1'b1;
        end
        CLS_QUOTE: begin
          emit            = 1'b1;
          res.slash_count = run >> 1;
          if (!run[0]) begin
            if (inq) close_pend_d = 1'b1;
            else     in_quotes_d  = 1'b1;
          end else begin
            res.char_valid = 1'b1;
            res.char_value = ChQuote;
          end
          add_n = {1'b0, res.slash_count} + 9'(res.char_valid);
          run_d = 8'd0;
        end
        CLS_SPACE, CLS_OTHER, CLS_NUL: begin
          emit            = 1'b1;
          res.slash_count = run;
          add_n           = {1'b0, run} + 9'd1;
          run_d           = 8'd0;
          if (item_i.cls == CLS_SPACE && !inq) begin
            res.arg_end = 1'b1;
            in_arg_d    = 1'b0;
          end else begin
            res.char_valid = 1'b1;
            res.char_value = item_i.ch;
          end
        end
        default: ;
      endcase
    end

    sum     = {1'b0, bytes_q} + 17'(add_n);
    bytes_d = sum[16] ? 16'hFFFF : sum[15:0];

    res.arg_count    = args_d;
    res.char_count   = bytes_d;
    res.run_overflow = ovf_d;

    // end of line: everything back to reset for the next line
    if (res.line_end) begin
      in_arg_d     = 1'b0;
      in_quotes_d  = 1'b0;
      close_pend_d = 1'b0;
      run_d        = 8'd0;
      ovf_d        = 1'b0;
      args_d       = 8'd0;
      bytes_d      = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_arg_q     <= 1'b0;
      in_quotes_q  <= 1'b0;
      close_pend_q <= 1'b0;
      run_q        <= 8'd0;
      ovf_q        <= 1'b0;
      args_q       <= 8'd0;
      bytes_q      <= 16'd0;
      res_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        in_arg_q     <= in_arg_d;
        in_quotes_q  <= in_quotes_d;
        close_pend_q <= close_pend_d;
        run_q        <= run_d;
        ovf_q        <= ovf_d;
        args_q       <= args_d;
        bytes_q      <= bytes_d;
      end
      if (item_ready_o) begin
        res_valid_q <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      res_q <= res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `CLAS_ASSERT_IMP(a_close_in_quotes, close_pend_q, in_quotes_q && in_arg_q)
  `CLAS_ASSERT(a_run_capped, run_q <= RunCap)
  `CLAS_ASSERT_NXT(a_line_clears, pop && emit && res.line_end,
                   !in_arg_q && args_q == 8'd0 && bytes_q == 16'd0)

endmodule

`default_nettype wire

// ===== rtl/command_line_argument_splitter.sv =====
// Command line argument splitter: one byte of a line in per item, one result item
// or none out. Splits on blanks outside quotes with the usual backslash/quote rules.
// Input channel: in_valid_i / in_ready_o with ch_i; a zero byte ends the line.
// Output channel: out_valid_o / out_ready_i with the result fields.
// Blanks outside an argument, and backslashes inside one, give no result item.
// Throughput: one byte per clock cycle while the receiver keeps up, set by the state
// update in the back stage; the front stage and a two-entry queue decouple input
// from execution so a stall on either side does not at once stop the other.
// Path: a byte is registered in the front stage, then held in a queue entry, and
// the back stage then registers its result in the output register.
// Reset: all splitter state clears, as at the start of a new line; the front, the
// queue and the output register empty.
// Receiver stall: the output register holds its item; the queue keeps taking bytes
// until it and the front register are full, then in_ready_o drops.
// The zero byte's result reports the line's totals; afterwards all counts restart.
// Depends on clas_pkg, clas_front, clas_queue and clas_back.
`default_nettype none

module command_line_argument_splitter (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [7:0]   ch_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [7:0]   slash_count_o,
  output logic         char_valid_o,
  output logic [7:0]   char_value_o,
  output logic         arg_start_o,
  output logic         arg_end_o,
  output logic         line_end_o,
  output logic [7:0]   arg_count_o,
  output logic [15:0]  char_count_o,
  output logic         run_overflow_o
);
  import clas_pkg::*;

  logic    f_valid, f_ready;
  item_t   f_item;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  clas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  clas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  clas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign slash_count_o  = res.slash_count;
  assign char_valid_o   = res.char_valid;
  assign char_value_o   = res.char_value;
  assign arg_start_o    = res.arg_start;
  assign arg_end_o      = res.arg_end;
  assign line_end_o     = res.line_end;
  assign arg_count_o    = res.arg_count;
  assign char_count_o   = res.char_count;
  assign run_overflow_o = res.run_overflow;

endmodule

`default_nettype wire

// ===== verif/command_line_argument_splitter_test.sv =====
// Self-checking bench for the command line argument splitter: drives byte streams,
// predicts each result item in a scoreboard class and compares on acceptance.
// Depends on clas_pkg and the command_line_argument_splitter top level only.
`timescale 1ns / 100ps

module command_line_argument_splitter_test;
  import clas_pkg::*;

  class split_scoreboard;
    bit          in_argument;
    bit          in_quotes;
    bit          close_pending;
    logic [7:0]  slash_run;
    bit          overflow_seen;
    logic [7:0]  args_seen;
    logic [15:0] bytes_written;
    result_t     expected_splits[$];
    int unsigned mismatches;

    function new();
      clear_line();
      mismatches = 0;
    endfunction

    function void clear_line();
      in_argument   = 1'b0;
      in_quotes     = 1'b0;
      close_pending = 1'b0;
      slash_run     = '0;
      overflow_seen = 1'b0;
      args_seen     = '0;
      bytes_written = '0;
    endfunction

    function void add_written(int unsigned n);
      int unsigned total;
      total = int'(bytes_written) + n;
      bytes_written = (total > 65535) ? 16'hFFFF : total[15:0];
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
    endfunction

    function string describe(result_t r);
      return $sformatf("slash=%0d cv=%0b ch=%h start=%0b end=%0b eol=%0b args=%0d chars=%0d ovf=%0b",
                       r.slash_count, r.char_valid, r.char_value, r.arg_start, r.arg_end,
                       r.line_end, r.arg_count, r.char_count, r.run_overflow);
    endfunction

    // works out the result item (if any) that one accepted byte causes
    function void predict_byte(logic [7:0] c);
      result_t r;
      bit      emit;
      bit      done;
      r    = '0;
      emit = 1'b0;
      done = 1'b0;
      // deferred close from a quote inside quotes
      if (close_pending) begin
        close_pending = 1'b0;
        in_quotes     = 1'b0;
        if (c == ChQuote) begin
          r.char_valid = 1'b1;
          r.char_value = ChQuote;
          add_written(1);
          emit = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && c == ChNul) begin
        r.line_end = 1'b1;
        if (in_argument) begin
          r.slash_count = slash_run;
          r.arg_end     = 1'b1;
          add_written(32'(slash_run) + 1);
        end
        emit = 1'b1;
        done = 1'b1;
      end
      if (!done && !in_argument) begin
        if (is_blank(c)) begin
          done = 1'b1;
        end else begin
          in_argument = 1'b1;
          if (args_seen != 8'hFF) args_seen++;
          r.arg_start = 1'b1;
          emit        = 1'b1;
          slash_run   = '0;
        end
      end
      if (!done && c == ChBackslash) begin
        if (slash_run < RunCap) slash_run++;
        else overflow_seen = 1'b1;
        done = 1'b1;
      end
      if (!done) begin
        emit = 1'b1;
        if (c == ChQuote) begin
          r.slash_count = slash_run >> 1;
          if (!slash_run[0]) begin
            if (in_quotes) close_pending = 1'b1;
            else in_quotes = 1'b1;
          end else begin
            r.char_valid = 1'b1;
            r.char_value = ChQuote;
          end
          add_written(32'(r.slash_count) + 32'(r.char_valid));
        end else if (is_blank(c) && !in_quotes) begin
          r.slash_count = slash_run;
          r.arg_end     = 1'b1;
          add_written(32'(slash_run) + 1);
          in_argument   = 1'b0;
        end else begin
          r.slash_count = slash_run;
          r.char_valid  = 1'b1;
          r.char_value  = c;
          add_written(32'(slash_run) + 1);
        end
        slash_run = '0;
      end
      if (emit) begin
        r.arg_count    = args_seen;
        r.char_count   = bytes_written;
        r.run_overflow = overflow_seen;
        expected_splits.insert(expected_splits.size(), r);
        if (r.line_end) clear_line();
      end
    endfunction

    function void check_split(result_t got);
      result_t want;
      if (expected_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result item: %s", $realtime, describe(got));
        return;
      end
      want = expected_splits.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                   describe(want), describe(got));
      end
    endfunction

    function int unsigned pending();
      return expected_splits.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  ch_i        = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  slash_count_o;
  logic        char_valid_o;
  logic [7:0]  char_value_o;
  logic        arg_start_o;
  logic        arg_end_o;
  logic        line_end_o;
  logic [7:0]  arg_count_o;
  logic [15:0] char_count_o;
  logic        run_overflow_o;

  split_scoreboard sb;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     bytes_sent     = 0;

  command_line_argument_splitter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slash_count_o  (slash_count_o),
    .char_valid_o   (char_valid_o),
    .char_value_o   (char_value_o),
    .arg_start_o    (arg_start_o),
    .arg_end_o      (arg_end_o),
    .line_end_o     (line_end_o),
    .arg_count_o    (arg_count_o),
    .char_count_o   (char_count_o),
    .run_overflow_o (run_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // input noted before output so a result offered in the same cycle as its byte would still find its item
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.predict_byte(ch_i);
      if (out_valid_o && out_ready_i) begin
        got.slash_count  = slash_count_o;
        got.char_valid   = char_valid_o;
        got.char_value   = char_value_o;
        got.arg_start    = arg_start_o;
        got.arg_end      = arg_end_o;
        got.line_end     = line_end_o;
        got.arg_count    = arg_count_o;
        got.char_count   = char_count_o;
        got.run_overflow = run_overflow_o;
        sb.check_split(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // mostly well-formed lines of words, quotes and backslash runs; some raw noise
  task automatic send_random_line();
    int unsigned pieces;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(0, 8);
      repeat (pieces) begin
        case ($urandom_range(0, 8))
          0, 1, 2: begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(1, 255)));
          end
          3: begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(random_blank());
          end
          4: begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(ChBackslash);
          end
          5: send_byte(ChQuote);
          6: begin
            send_byte(ChQuote);
            send_byte(ChQuote);
          end
          7: begin
            n = $urandom_range(0, 4);
            repeat (n) send_byte(ChBackslash);
            send_byte(ChQuote);
          end
          default: send_byte(random_blank());
        endcase
      end
    end
    send_byte(ChNul);
  endtask

  // one clipped backslash run; the overflow flag has to stay up to the line end
  task automatic send_long_runs_line();
    repeat (257) send_byte(ChBackslash);
    send_byte("x");
    send_byte("y");
    send_byte(ChNul);
  endtask

  task automatic send_many_args_line();
    repeat (260) begin
      send_byte("a");
      send_byte(ChSpace);
    end
    send_byte(ChNul);
  endtask

  initial begin
    logic [7:0]  opening[$];
    int unsigned target;
    sb = new();
    opening = '{ChNul, ChSpace, ChTab, ChCr, ChLf, "a", 8'hFF,
                ChBackslash, ChBackslash, ChQuote, ChSpace,
                ChBackslash, ChBackslash, ChBackslash, ChQuote,
                ChQuote, ChQuote, ChQuote, ChQuote, "b",
                ChBackslash, "c", ChTab, ChBackslash, ChQuote, ChNul};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 53; end
        default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
      endcase
      if (phase == 0) send_long_runs_line();
      if (phase == 3) send_many_args_line();
      target = bytes_sent + 150;
      while (bytes_sent < target) send_random_line();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
